FILE: sv/tews_pkg.sv
// ----------------------------------------------------------------------------
// tews_pkg
// Shared types and constants of the event-wait task scheduler.
// ----------------------------------------------------------------------------
package tews_pkg;

  localparam logic [2:0] FN_POST  = 3'd0;
  localparam logic [2:0] FN_WAIT  = 3'd1;
  localparam logic [2:0] FN_CLEAR = 3'd2;
  localparam logic [2:0] FN_SCHED = 3'd3;
  localparam logic [2:0] FN_SETST = 3'd4;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_WAITING = 2'd1;

  localparam logic [31:0] HALF = 32'h8000_0000;

  localparam logic CFG_TIMER   = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  task_req;
    logic [31:0] value;
    logic [31:0] wait_time;
    logic        force_req;
    logic [1:0]  new_state;
  } tews_in_t;

  typedef struct packed {
    logic [2:0]  out_task;
    logic [31:0] out_value;
    logic        resched;
    logic        is_wake;
    logic [31:0] time_now;
    logic        last;
  } tews_out_t;

endpackage

FILE: sv/tews_out_reg.sv
// ----------------------------------------------------------------------------
// tews_out_reg
// Output holding register: keeps one result until the sink takes it.
// ----------------------------------------------------------------------------
module tews_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tews_pkg::tews_out_t load_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output tews_pkg::tews_out_t out_data
);
  logic                full_r;
  tews_pkg::tews_out_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (load) begin
      full_r <= 1'b1;
    end else if (!out_stall) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign full      = full_r && out_stall;
  assign out_valid = full_r;
  assign out_data  = data_r;
endmodule

FILE: sv/task_event_wait_scheduler_core.sv
// ----------------------------------------------------------------------------
// task_event_wait_scheduler_core
// Event-wait scheduler: per-task state walked one entry a cycle when unstalled.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// in_     | input     | in_valid/in_stall| tews_in_t
// out_    | output    | out_valid/out_stall | tews_out_t
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Post runs a deadline sweep, an event sweep and a summary, with one result
// per woken task; schedule walks the tasks round-robin; wait, clear and set
// state are handled in the S_ONE state.
// The shared compare/update unit sees one task entry per cycle unless stalled.
// Reset (rst_n low, synchronous) sets every task ready and clears task state.
// A stalled result holds the sequencer; no new item enters until done.
module task_event_wait_scheduler_core #(
  parameter int NUM_TASKS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tews_pkg::tews_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tews_pkg::tews_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  localparam int TW = $clog2(NUM_TASKS);

  typedef enum logic [2:0] {S_IDLE, S_DL, S_EV, S_SUM, S_SCH1, S_SCH2, S_ONE} st_t;

  st_t st_r;
  logic [1:0]  run_r [NUM_TASKS];
  logic [31:0] pend_r [NUM_TASKS];
  logic [31:0] wmask_r [NUM_TASKS];
  logic [31:0] dl_r [NUM_TASKS];
  logic [31:0] ms_r, tmr_r, tmo_r;
  tews_pkg::tews_in_t it_r;
  logic rebase_r;
  logic [TW:0] idx_r;
  logic [TW:0] cnt_r;
  logic [TW-1:0] ix;
  logic [TW-1:0] nxt_r;
  logic ok;
  logic load;
  logic full;
  tews_pkg::tews_out_t ld;

  // Out-of-range task indexes fail this check (task_req is 3 bits wide)
  assign ok = ({29'd0, it_r.task_req} < 32'(NUM_TASKS));
  assign ix = idx_r[TW-1:0];
  assign in_stall  = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmr_r <= 32'd1;
      tmo_r <= 32'h0001_0000;
    end else if (cfg_valid) begin
      if (cfg_index == tews_pkg::CFG_TIMER) tmr_r <= cfg_data;
      else tmo_r <= cfg_data;
    end
  end

  // Main sequencer: each cycle touches at most one task entry.
  always_ff @(posedge clk) begin
    logic [31:0] d, sig, ms1, ret, pe, wm;
    logic hit;
    logic [TW-1:0] t;
    tews_pkg::tews_out_t res;
    if (!rst_n) begin
      st_r <= S_IDLE;
      ms_r <= '0;
      load <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        run_r[i] <= tews_pkg::ST_READY; pend_r[i] <= '0;
        wmask_r[i] <= '0; dl_r[i] <= '0;
      end
    end else begin
      load <= 1'b0;
      t = TW'(it_r.task_req);
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            it_r  <= in_data;
            idx_r <= '0;
            case (in_data.func)
              tews_pkg::FN_POST: begin
                ms1 = ms_r + ((in_data.value & tmr_r) != 0 ? 32'd1 : 32'd0);
                rebase_r <= ms1[31];
                ms_r <= {1'b0, ms1[30:0]};
                st_r <= S_DL;
              end
              tews_pkg::FN_SCHED: st_r <= S_SCH1;
              default: st_r <= S_ONE;
            endcase
          end
        end
        S_DL: begin
          d = dl_r[ix];
          if (d != 0) begin
            if (rebase_r) begin
              d = d - tews_pkg::HALF;
              if (d == 0) d = 32'd1;
              hit = (d ^ tews_pkg::HALF) < (ms_r ^ tews_pkg::HALF);
            end else begin
              hit = d < ms_r;
            end
            dl_r[ix] <= hit ? 32'd0 : d;
            if (hit) pend_r[ix] <= pend_r[ix] | tmo_r;
          end
          if (idx_r == (TW+1)'(NUM_TASKS - 1)) begin
            idx_r <= '0; st_r <= S_EV;
          end else idx_r <= idx_r + 1'b1;
        end
        S_EV: begin
          if (!full && !load) begin
            pe  = pend_r[ix] | it_r.value;
            sig = wmask_r[ix] & pe;
            if (run_r[ix] == tews_pkg::ST_WAITING && sig != 0) begin
              run_r[ix] <= tews_pkg::ST_READY;
              pend_r[ix] <= pe & ~sig;
              wmask_r[ix] <= '0;
              ld <= '{out_task: 3'(ix), out_value: sig, resched: 1'b0, is_wake: 1'b1,
                      time_now: ms_r, last: 1'b0};
              load <= 1'b1;
            end else pend_r[ix] <= pe;
            if (idx_r == (TW+1)'(NUM_TASKS - 1)) st_r <= S_SUM;
            else idx_r <= idx_r + 1'b1;
          end
        end
        S_SUM: begin
          if (!full && !load) begin
            ld <= '{out_task: 3'd0, out_value: 32'd0, resched: 1'b0, is_wake: 1'b0,
                    time_now: ms_r, last: 1'b1};
            load <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_SCH1: begin
          // Keep the running task unless a reschedule is due.
          if (ok && !it_r.force_req && run_r[t] == tews_pkg::ST_READY
              && t != TW'(NUM_TASKS - 1)) begin
            nxt_r <= t; st_r <= S_SCH2; cnt_r <= '0;
          end else begin
            // Start after the running task, wrap over tasks below the idle one.
            nxt_r <= TW'(NUM_TASKS - 1);
            idx_r <= (ok && {1'b0, t} < (TW+1)'(NUM_TASKS - 2)) ?
                     (TW+1)'(t) + 1'b1 : '0;
            cnt_r <= (TW+1)'(NUM_TASKS - 1);
            st_r  <= S_SCH2;
          end
        end
        S_SCH2: begin
          // Walk round-robin; stop at the first ready task or after a full lap.
          if (cnt_r == '0) begin
            if (!full && !load) begin
              ld <= '{out_task: 3'(nxt_r), out_value: 32'd0, resched: 1'b0,
                      is_wake: 1'b0, time_now: ms_r, last: 1'b1};
              load <= 1'b1; st_r <= S_IDLE;
            end
          end else if (run_r[ix] == tews_pkg::ST_READY) begin
            nxt_r <= ix; cnt_r <= '0;
          end else begin
            idx_r <= (idx_r == (TW+1)'(NUM_TASKS - 2)) ? '0 : idx_r + 1'b1;
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_ONE: begin
          if (!full && !load) begin
            ret = '0;
            res = '{out_task: (it_r.func > tews_pkg::FN_SETST) ? 3'd0 : it_r.task_req,
                    out_value: 32'd0, resched: 1'b0, is_wake: 1'b0,
                    time_now: ms_r, last: 1'b1};
            if (ok && it_r.func == tews_pkg::FN_WAIT) begin
              ret = it_r.value & pend_r[t];
              res.out_value = ret;
              if (ret != 0) pend_r[t] <= pend_r[t] & ~ret;
              else begin
                wm = it_r.value;
                if (it_r.wait_time != 0) begin
                  run_r[t] <= tews_pkg::ST_WAITING;
                  res.resched = 1'b1;
                  if (!it_r.wait_time[31]) begin
                    dl_r[t] <= ms_r + it_r.wait_time;
                    wm = wm | tmo_r;
                  end
                end
                wmask_r[t] <= wm;
              end
            end else if (ok && it_r.func == tews_pkg::FN_CLEAR) begin
              ret = it_r.value & pend_r[t];
              res.out_value = ret;
              pe = pend_r[t] & ~ret;
              if (it_r.value != 0) begin
                if (it_r.value[31]) pe = pe & ~tmo_r;
                else dl_r[t] <= ms_r + it_r.value;
              end
              pend_r[t] <= pe;
            end else if (ok && it_r.func == tews_pkg::FN_SETST) begin
              run_r[t] <= it_r.new_state;
            end
            ld <= res;
            load <= 1'b1; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  tews_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .load(load), .load_data(ld), .full(full),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
